// ===== sv/tkf_pkg.sv =====
// Shared types, widths, register indexes and saturation helpers for the
// two-state tilt Kalman filter. No dependencies.
package tkf_pkg;

    localparam int DATA_WIDTH = 32;        // angle and rate word width
    localparam int CFG_W      = 32;        // configuration register width
    localparam int COV_W      = 32;        // covariance and gain width
    localparam int FRAC       = 28;        // Q4.28 fraction bits
    localparam int DEN_W      = COV_W + 2; // r_meas_noise + cov_aa
    // multiplier operand A, signed: angle error or covariance sums
    localparam int AW  = (DATA_WIDTH + 2 > COV_W + 3) ? DATA_WIDTH + 2 : COV_W + 3;
    localparam int BW  = CFG_W + 1;        // operand B, signed
    localparam int MW  = 64;               // rounded product, signed
    localparam int SW  = MW + 2;           // sums before saturation

    localparam logic [1:0] CFG_Q_ANGLE = 2'd0;
    localparam logic [1:0] CFG_Q_BIAS  = 2'd1;
    localparam logic [1:0] CFG_R_MEAS  = 2'd2;
    localparam logic [1:0] CFG_DT      = 2'd3;

    localparam logic [CFG_W-1:0] RST_Q_ANGLE = 32'd268435;
    localparam logic [CFG_W-1:0] RST_Q_BIAS  = 32'd805306;
    localparam logic [CFG_W-1:0] RST_R_MEAS  = 32'd134217728;
    localparam logic [CFG_W-1:0] RST_DT      = 32'd1342177;
    localparam logic [COV_W-1:0] COV_ONE     = 32'h1000_0000;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] angle_meas;
        logic signed [DATA_WIDTH-1:0] gyro_meas;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] angle_out;
        logic signed [DATA_WIDTH-1:0] rate_out;
    } t_out_beat;

    function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
        lo = ~hi;
        if (v > hi)      return hi[DATA_WIDTH-1:0];
        else if (v < lo) return lo[DATA_WIDTH-1:0];
        else             return v[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'({1'b0, {(COV_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi)      return hi[COV_W-1:0];
        else if (v < lo) return lo[COV_W-1:0];
        else             return v[COV_W-1:0];
    endfunction

endpackage

// ===== sv/tkf_mul.sv =====
// Shared sign-magnitude multiplier, 16 bits of A per cycle, with Q4.28
// round-half-away and cap at 2^62. Depends on tkf_pkg.
module tkf_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [tkf_pkg::AW-1:0] i_a,
    input  logic signed [tkf_pkg::BW-1:0] i_b,
    output logic                        o_done,
    output logic signed [tkf_pkg::MW-1:0] o_res
);
    import tkf_pkg::*;

    localparam int NCH = (AW + 15) / 16;
    localparam int AP  = NCH * 16;
    localparam int PW  = AP + CFG_W;
    localparam int CW  = $clog2(NCH + 1);
    localparam int XW  = (PW - FRAC + 1 > MW) ? PW - FRAC + 1 : MW;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC - 1);
    localparam logic [XW-1:0] CAP = XW'(1) << 62;

    logic [AP-1:0]    r_amag;
    logic [CFG_W-1:0] r_bmag;
    logic             r_neg;
    logic [PW-1:0]    r_acc;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic signed [MW-1:0] r_res;

    logic [AW-1:0]      amag;
    logic [BW-1:0]      bmag;
    logic [PW:0]        rsum;
    logic [PW-FRAC:0]   rnd;
    logic [MW-1:0]      umag;

    always_comb begin
        amag = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
        bmag = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);
        rsum = (PW+1)'(r_acc) + HALF;
        rnd  = rsum[PW:FRAC];
        umag = (XW'(rnd) > CAP) ? MW'(CAP) : MW'(rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NCH);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CW'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_amag <= AP'(amag);
            r_bmag <= bmag[CFG_W-1:0];
            r_neg  <= i_a[AW-1] ^ i_b[BW-1];
            r_acc  <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_acc  <= (r_acc << 16) + (PW'(r_bmag) * PW'(r_amag[AP-1 -: 16]));
            r_amag <= r_amag << 16;
        end else if (r_busy) begin
            r_res  <= r_neg ? -$signed(umag) : $signed(umag);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// ===== sv/tkf_div.sv =====
// Gain divider: (|num| << 28) / |den|, restoring, one quotient bit a cycle,
// saturated to signed Q4.28, zero on a zero divisor. Depends on tkf_pkg.
module tkf_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [tkf_pkg::COV_W-1:0] i_num,
    input  logic signed [tkf_pkg::DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic signed [tkf_pkg::COV_W-1:0] o_res
);
    import tkf_pkg::*;

    localparam int QW = COV_W;            // quotient bits formed
    localparam int CW = $clog2(QW + 1);
    localparam int LW = QW + 6;           // overflow compare width

    logic [DEN_W-1:0] r_dmag;
    logic [DEN_W-1:0] r_rem;
    logic [QW-1:0]    r_lo;
    logic [QW-1:0]    r_q;
    logic             r_neg;
    logic             r_ovf;
    logic             r_zero;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic signed [COV_W-1:0] r_res;

    logic [COV_W-1:0] nmag;
    logic [DEN_W-1:0] dmag;
    logic [DEN_W:0]   tmp;
    logic             fit;

    always_comb begin
        nmag = i_num[COV_W-1] ? COV_W'(-i_num) : COV_W'(i_num);
        dmag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        tmp  = {r_rem, r_lo[QW-1]};
        fit  = tmp >= (DEN_W+1)'(r_dmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                if (r_cnt != '0 && !r_ovf && !r_zero) begin
                    r_cnt <= r_cnt - CW'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dmag <= dmag;
            r_rem  <= DEN_W'(nmag[COV_W-1:4]);
            r_lo   <= {nmag[3:0], {(QW-4){1'b0}}};
            r_q    <= '0;
            r_neg  <= i_num[COV_W-1] ^ i_den[DEN_W-1];
            r_zero <= (i_den == '0);
            // quotient reaches 2^32 when |num| >= |den| * 16
            r_ovf  <= LW'(nmag) >= (LW'(dmag) << 4);
        end else if (r_busy && r_cnt != '0 && !r_ovf && !r_zero) begin
            r_rem <= fit ? DEN_W'(tmp - (DEN_W+1)'(r_dmag)) : tmp[DEN_W-1:0];
            r_lo  <= r_lo << 1;
            r_q   <= {r_q[QW-2:0], fit};
        end else if (r_busy) begin
            if (r_zero)
                r_res <= '0;
            else if (r_neg)
                r_res <= (r_ovf || r_q > {1'b1, {(QW-1){1'b0}}}) ?
                         $signed({1'b1, {(COV_W-1){1'b0}}}) : -$signed(r_q);
            else
                r_res <= (r_ovf || r_q[QW-1]) ?
                         $signed({1'b0, {(COV_W-1){1'b1}}}) : $signed(r_q);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// ===== sv/tilt_kalman_filter_2state_core.sv =====
// Two-state tilt Kalman filter core (angle and gyro bias), top level.
// Depends on tkf_pkg, tkf_mul and tkf_div.
//
//  channel | direction | handshake              | beat
//  in      | input     | i_in_valid / o_in_stall | t_in_beat  (angle, gyro)
//  out     | output    | o_out_valid / i_out_stall | t_out_beat (angle, rate)
//  cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// Each beat runs ten multiplies through the shared 32x16 multiplier (NCH =
// ceil(AW/16) = 3 chunks of A at DATA_WIDTH 32), two gain divides through the
// one-bit-a-cycle divider, then loads the output register and returns to idle.
// A divide ends early on a zero divisor or a gain overflow.
// o_in_stall is high from acceptance until the result is loaded into the
// output register; the next beat may enter while that result still waits.
// Reset (synchronous, active low) restores the noise defaults, zeroes the
// estimates and sets the covariance to identity. No clearing pass.
module tilt_kalman_filter_2state_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  tkf_pkg::t_in_beat            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output tkf_pkg::t_out_beat           o_out_data,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [tkf_pkg::CFG_W-1:0]    i_cfg_data
);
    import tkf_pkg::*;

    localparam int DW = DATA_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // operation sequence
    localparam logic [3:0] OP_ANGLE_P = 4'd0;  // angle += (gm - bias) * dt
    localparam logic [3:0] OP_AA_P    = 4'd1;  // aa += pdot0 * dt
    localparam logic [3:0] OP_AB_P    = 4'd2;  // ab, ba += -bb * dt
    localparam logic [3:0] OP_BB_P    = 4'd3;  // bb += qb * dt
    localparam logic [3:0] OP_K0      = 4'd4;
    localparam logic [3:0] OP_K1      = 4'd5;
    localparam logic [3:0] OP_BA_C    = 4'd6;  // ba -= k1 * aa
    localparam logic [3:0] OP_BB_C    = 4'd7;  // bb -= k1 * ab
    localparam logic [3:0] OP_AA_C    = 4'd8;  // aa -= k0 * aa
    localparam logic [3:0] OP_AB_C    = 4'd9;  // ab -= k0 * ab
    localparam logic [3:0] OP_BIAS_C  = 4'd10; // bias += k1 * err
    localparam logic [3:0] OP_ANGLE_C = 4'd11; // angle += k0 * err
    localparam logic [3:0] OP_END     = 4'd12;

    logic [CFG_W-1:0] r_qa, r_qb, r_rn, r_dt;
    logic signed [DW-1:0]    r_am, r_gm, r_angle, r_bias;
    logic signed [COV_W-1:0] r_aa, r_ab, r_ba, r_bb, r_k0, r_k1;
    logic [1:0] r_state;
    logic [3:0] r_op;
    logic       r_go;
    logic       r_ovld;
    t_out_beat  r_out;

    logic [3:0] n_op;
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [MW-1:0]    mul_res;
    logic                    mul_done;
    logic signed [COV_W-1:0] div_num;
    logic signed [DEN_W-1:0] div_den;
    logic signed [COV_W-1:0] div_res;
    logic                    div_done;
    logic signed [SW-1:0]    m;
    logic signed [AW-1:0]    err;
    logic                    in_acc;

    assign in_acc = i_in_valid && !o_in_stall;
    assign n_op   = r_op + 4'd1;
    assign m      = SW'(mul_res);
    assign err    = AW'(r_am) - AW'(r_angle);

    // operand select for the shared multiplier and the divider
    always_comb begin
        mul_a = '0;
        mul_b = BW'(r_dt);
        case (r_op)
            OP_ANGLE_P: mul_a = AW'(r_gm) - AW'(r_bias);
            OP_AA_P:    mul_a = AW'(r_qa) - AW'(r_ab) - AW'(r_ba);
            OP_AB_P:    mul_a = -AW'(r_bb);
            OP_BB_P:    mul_a = AW'(r_qb);
            OP_BA_C:    begin mul_a = AW'(r_aa);  mul_b = BW'(r_k1); end
            OP_BB_C:    begin mul_a = AW'(r_ab);  mul_b = BW'(r_k1); end
            OP_AA_C:    begin mul_a = AW'(r_aa);  mul_b = BW'(r_k0); end
            OP_AB_C:    begin mul_a = AW'(r_ab);  mul_b = BW'(r_k0); end
            OP_BIAS_C:  begin mul_a = err;        mul_b = BW'(r_k1); end
            OP_ANGLE_C: begin mul_a = err;        mul_b = BW'(r_k0); end
            default:    mul_a = '0;
        endcase
        div_num = (r_op == OP_K1) ? r_ba : r_aa;
        div_den = $signed({2'b00, r_rn}) + DEN_W'(r_aa);
    end

    tkf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && r_state == S_MUL),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    tkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && r_state == S_DIV),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_ANGLE_P;
            r_go    <= 1'b0;
            r_ovld  <= 1'b0;
            r_qa    <= RST_Q_ANGLE;
            r_qb    <= RST_Q_BIAS;
            r_rn    <= RST_R_MEAS;
            r_dt    <= RST_DT;
            r_angle <= '0;
            r_bias  <= '0;
            r_aa    <= COV_ONE;
            r_ab    <= '0;
            r_ba    <= '0;
            r_bb    <= COV_ONE;
        end else begin
            r_go <= 1'b0;
            if (o_out_valid && !i_out_stall)
                r_ovld <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_Q_ANGLE: r_qa <= i_cfg_data;
                    CFG_Q_BIAS:  r_qb <= i_cfg_data;
                    CFG_R_MEAS:  r_rn <= i_cfg_data;
                    CFG_DT:      r_dt <= i_cfg_data;
                    default:     ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_MUL;
                        r_op    <= OP_ANGLE_P;
                        r_go    <= 1'b1;
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        case (r_op)
                            OP_ANGLE_P: r_angle <= sat_dw(SW'(r_angle) + m);
                            OP_AA_P:    r_aa    <= sat_cov(SW'(r_aa) + m);
                            OP_AB_P: begin
                                r_ab <= sat_cov(SW'(r_ab) + m);
                                r_ba <= sat_cov(SW'(r_ba) + m);
                            end
                            OP_BB_P:    r_bb    <= sat_cov(SW'(r_bb) + m);
                            OP_BA_C:    r_ba    <= sat_cov(SW'(r_ba) - m);
                            OP_BB_C:    r_bb    <= sat_cov(SW'(r_bb) - m);
                            OP_AA_C:    r_aa    <= sat_cov(SW'(r_aa) - m);
                            OP_AB_C:    r_ab    <= sat_cov(SW'(r_ab) - m);
                            OP_BIAS_C:  r_bias  <= sat_dw(SW'(r_bias) + m);
                            OP_ANGLE_C: r_angle <= sat_dw(SW'(r_angle) + m);
                            default:    ;
                        endcase
                        r_op <= n_op;
                        if (n_op == OP_K0) begin
                            r_state <= S_DIV;
                            r_go    <= 1'b1;
                        end else if (n_op == OP_END) begin
                            r_state <= S_OUT;
                        end else begin
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_op == OP_K1)
                            r_k1 <= div_res;
                        else
                            r_k0 <= div_res;
                        r_op <= n_op;
                        r_go <= 1'b1;
                        if (n_op != OP_K1)
                            r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    // wait while an older result is still held
                    if (!r_ovld || !i_out_stall) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // beat capture and output payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_am <= i_in_data.angle_meas;
            r_gm <= i_in_data.gyro_meas;
        end
        if (r_state == S_OUT && (!r_ovld || !i_out_stall)) begin
            r_out.angle_out <= r_angle;
            r_out.rate_out  <= sat_dw(SW'(r_gm) - SW'(r_bias));
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    // checks
    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == S_MUL)
        else $error("multiplier result outside multiply step");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider result outside gain step");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after beat accepted");

endmodule

// ===== sim/tilt_kalman_filter_2state_core_tb.sv =====
// Self-checking testbench for tilt_kalman_filter_2state_core: random and directed
// beats against an in-bench fixed-point filter model. Depends on tkf_pkg and tilt_kalman_filter_2state_core.
module tilt_kalman_filter_2state_core_tb;
    import tkf_pkg::*;

    localparam int  SETTLE_CYC = 300;        // well above one beat's processing time
    localparam int  CYC_LIMIT  = 1_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;
    logic      i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = CFG_Q_ANGLE;
    logic [CFG_W-1:0] i_cfg_data = '0;

    tilt_kalman_filter_2state_core u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter state mirror
    longint q_ang, q_bias, r_meas, dt_cfg;
    longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;

    t_in_beat  pending_beats[$];
    t_out_beat expected_outs[$];
    int  n_fail = 0;
    bit  calm = 1'b0;   // no idling on either side in the closing stretch
    int  in_gap = 0;
    int  out_gap = 0;
    int  cyc = 0;

    function automatic longint sat_to(input longint v, input int bits);
        longint lim;
        lim = longint'(1) << (bits - 1);
        if (v > lim - 1) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Q4.28 product, round half away from zero, magnitude capped at 2^62
    function automatic longint qmul(input longint a, input longint b);
        logic [127:0] p;
        longint unsigned ma, mb;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = {64'd0, ma} * {64'd0, mb};
        p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
        if (p > (128'd1 << 62)) p = 128'd1 << 62;
        return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint gain_q(input longint num, input longint den);
        logic [127:0] q;
        longint unsigned mn, md;
        if (den == 0) return 0;
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q = ({64'd0, mn} << FRAC) / {64'd0, md};
        if ((num < 0) != (den < 0)) begin
            if (q > (128'd1 << 31)) q = 128'd1 << 31;
            return -longint'(q[63:0]);
        end
        if (q > (128'd1 << 31) - 1) q = (128'd1 << 31) - 1;
        return longint'(q[63:0]);
    endfunction

    function automatic void filter_step(input t_in_beat b);
        longint am, gm, pdot, old_bb, err, e, k0, k1, t0, t1, rate;
        t_out_beat r;
        am = longint'(b.angle_meas);
        gm = longint'(b.gyro_meas);
        // predict
        angle_est = sat_to(angle_est + qmul(gm - bias_est, dt_cfg), DATA_WIDTH);
        pdot   = q_ang - p_ab - p_ba;
        old_bb = p_bb;
        p_aa = sat_to(p_aa + qmul(pdot, dt_cfg), COV_W);
        p_ab = sat_to(p_ab + qmul(-old_bb, dt_cfg), COV_W);
        p_ba = sat_to(p_ba + qmul(-old_bb, dt_cfg), COV_W);
        p_bb = sat_to(old_bb + qmul(q_bias, dt_cfg), COV_W);
        // correct
        err = am - angle_est;
        e   = r_meas + p_aa;
        k0  = gain_q(p_aa, e);
        k1  = gain_q(p_ba, e);
        t0  = p_aa;
        t1  = p_ab;
        p_aa = sat_to(p_aa - qmul(k0, t0), COV_W);
        p_ab = sat_to(p_ab - qmul(k0, t1), COV_W);
        p_ba = sat_to(p_ba - qmul(k1, t0), COV_W);
        p_bb = sat_to(p_bb - qmul(k1, t1), COV_W);
        angle_est = sat_to(angle_est + qmul(k0, err), DATA_WIDTH);
        bias_est  = sat_to(bias_est + qmul(k1, err), DATA_WIDTH);
        rate = sat_to(gm - bias_est, DATA_WIDTH);
        r.angle_out = angle_est[DATA_WIDTH-1:0];
        r.rate_out  = rate[DATA_WIDTH-1:0];
        expected_outs.push_back(r);
    endfunction

    // Input driver: a beat stays put while stalled; idle bursts only between beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) filter_step(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    i_in_valid <= 1'b0;
                    in_gap = in_gap - 1;
                end else if (pending_beats.size() > 0) begin
                    i_in_data  <= pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 3);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor with random stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_outs.size() == 0) begin
                    $error("unexpected output beat: angle_out %0d rate_out %0d",
                           o_out_data.angle_out, o_out_data.rate_out);
                    n_fail++;
                end else begin
                    t_out_beat x;
                    x = expected_outs.pop_front();
                    if (o_out_data.angle_out !== x.angle_out) begin
                        $error("angle_out: expected %0d, actual %0d",
                               x.angle_out, o_out_data.angle_out);
                        n_fail++;
                    end
                    if (o_out_data.rate_out !== x.rate_out) begin
                        $error("rate_out: expected %0d, actual %0d",
                               x.rate_out, o_out_data.rate_out);
                        n_fail++;
                    end
                end
            end
            if (out_gap > 0) begin
                i_out_stall <= 1'b1;
                out_gap = out_gap - 1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                out_gap = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYC_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_Q_ANGLE: q_ang  = val;
            CFG_Q_BIAS:  q_bias = val;
            CFG_R_MEAS:  r_meas = val;
            default:     dt_cfg = val;
        endcase
    endtask

    task automatic set_noise(input logic [CFG_W-1:0] qa, input logic [CFG_W-1:0] qb,
                             input logic [CFG_W-1:0] rm, input logic [CFG_W-1:0] ts);
        write_reg(CFG_Q_ANGLE, qa);
        write_reg(CFG_Q_BIAS, qb);
        write_reg(CFG_R_MEAS, rm);
        write_reg(CFG_DT, ts);
    endtask

    task automatic queue_beat(input logic [31:0] a, input logic [31:0] g);
        t_in_beat b;
        b.angle_meas = a;
        b.gyro_meas  = g;
        pending_beats.push_back(b);
    endtask

    // Mostly plausible IMU samples, some full-range noise
    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                queue_beat($urandom, $urandom);
            else
                queue_beat(32'($signed($urandom_range(0, 180 << 16)) - (90 << 16)),
                           32'($signed($urandom_range(0, 1000 << 16)) - (500 << 16)));
        end
    endtask

    // Let everything queued drain, then give the core time to go idle
    task automatic drain;
        while (pending_beats.size() > 0 || i_in_valid || expected_outs.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    initial begin
        q_ang = RST_Q_ANGLE;  q_bias = RST_Q_BIAS;
        r_meas = RST_R_MEAS;  dt_cfg = RST_DT;
        angle_est = 0;  bias_est = 0;
        p_aa = COV_ONE; p_ab = 0; p_ba = 0; p_bb = COV_ONE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults, field extremes
        set_noise(RST_Q_ANGLE, RST_Q_BIAS, RST_R_MEAS, RST_DT);
        queue_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_beat(32'h8000_0000, 32'h8000_0000);
        queue_beat(32'h0, 32'h0);
        queue_beat(32'h7FFF_FFFF, 32'h8000_0000);
        queue_beat(32'h8000_0000, 32'h7FFF_FFFF);
        queue_beat(32'hFFFF_FFFF, 32'h0000_0001);
        queue_beat(32'h0005_0000, 32'hFFFF_0000);
        drain();

        // zero measurement noise and frozen time: first gain is one, then the
        // divisor collapses to zero and both gains drop to zero
        set_noise(32'h0, 32'h0, 32'h0, 32'h0);
        queue_beat(32'h000A_0000, 32'h0001_0000);
        queue_beat(32'hFFF6_0000, 32'h0002_0000);
        queue_beat(32'h0000_0000, 32'h7FFF_FFFF);
        queue_beat(32'h1234_5678, 32'h8000_0000);
        drain();

        // every register at its top: covariance runs into saturation
        set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_beat(32'h7FFF_FFFF, 32'h8000_0000);
        queue_beat(32'h8000_0000, 32'h7FFF_FFFF);
        queue_beat(32'h0, 32'h0);
        queue_random(4);
        drain();

        // random settings, negative covariance paths likely
        set_noise($urandom, $urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h1000),
                  $urandom_range(0, 32'h2000_0000));
        queue_random(60);
        drain();

        set_noise(RST_Q_ANGLE, RST_Q_BIAS, RST_R_MEAS, RST_DT);
        queue_random(500);
        while (pending_beats.size() > 60) @(posedge i_clk);
        calm = 1'b1;
        queue_random(60);
        drain();

        if (n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
